@@ hw/rtl/gcr_pkg.sv @@
package gcr_pkg;

    localparam int unsigned GlyphCols  = 5;
    localparam int unsigned GlyphRows  = 7;
    localparam int unsigned GlyphBits  = GlyphCols * GlyphRows;
    localparam int unsigned BitIdxW    = $clog2(GlyphBits);
    localparam int unsigned ColW       = $clog2(GlyphCols);
    localparam int unsigned RowW       = $clog2(GlyphRows);

    localparam logic [7:0]  CodeFirst   = 8'd32;
    localparam logic [7:0]  CodeLast    = 8'd125;
    localparam logic [7:0]  AlphaOpaque = 8'hFF;
    localparam logic [10:0] CellOffsetX = 11'd2;

    typedef struct packed {
        logic [7:0] char_code;
        logic [9:0] pos_x;
        logic [9:0] pos_y;
    } in_item_t;

    typedef struct packed {
        logic [10:0] square_x;
        logic [10:0] square_y;
        logic [31:0] fill_argb;
        logic        last_square;
    } out_item_t;

    // bit col*7+row set for each lit pixel
    typedef struct packed {
        logic [GlyphBits-1:0] pixels;
        logic [9:0]           pos_x;
        logic [9:0]           pos_y;
    } job_t;

    // column bytes, column 0 in the top byte
    function automatic logic [39:0] glyph_cols(input logic [6:0] idx);
        logic [39:0] c;
        begin
            case (idx)
                7'd0:  c = 40'h00_00_00_00_00;
                7'd1:  c = 40'h00_00_5F_00_00;
                7'd2:  c = 40'h00_07_00_07_00;
                7'd3:  c = 40'h14_7F_14_7F_14;
                7'd4:  c = 40'h24_2A_7F_2A_12;
                7'd5:  c = 40'h23_13_08_64_62;
                7'd6:  c = 40'h36_49_55_22_50;
                7'd7:  c = 40'h00_05_03_00_00;
                7'd8:  c = 40'h00_1C_22_41_00;
                7'd9:  c = 40'h00_41_22_1C_00;
                7'd10: c = 40'h08_2A_1C_2A_08;
                7'd11: c = 40'h08_08_3E_08_08;
                7'd12: c = 40'h00_50_30_00_00;
                7'd13: c = 40'h08_08_08_08_08;
                7'd14: c = 40'h00_60_60_00_00;
                7'd15: c = 40'h20_10_08_04_02;
                7'd16: c = 40'h3E_51_49_45_3E;
                7'd17: c = 40'h00_42_7F_40_00;
                7'd18: c = 40'h42_61_51_49_46;
                7'd19: c = 40'h21_41_45_4B_31;
                7'd20: c = 40'h18_14_12_7F_10;
                7'd21: c = 40'h27_45_45_45_39;
                7'd22: c = 40'h3C_4A_49_49_30;
                7'd23: c = 40'h01_71_09_05_03;
                7'd24: c = 40'h36_49_49_49_36;
                7'd25: c = 40'h06_49_49_29_1E;
                7'd26: c = 40'h00_36_36_00_00;
                7'd27: c = 40'h00_56_36_00_00;
                7'd28: c = 40'h00_08_14_22_41;
                7'd29: c = 40'h14_14_14_14_14;
                7'd30: c = 40'h41_22_14_08_00;
                7'd31: c = 40'h02_01_51_09_06;
                7'd32: c = 40'h32_49_79_41_3E;
                7'd33: c = 40'h7E_11_11_11_7E;
                7'd34: c = 40'h7F_49_49_49_36;
                7'd35: c = 40'h3E_41_41_41_22;
                7'd36: c = 40'h7F_41_41_22_1C;
                7'd37: c = 40'h7F_49_49_49_41;
                7'd38: c = 40'h7F_09_09_01_01;
                7'd39: c = 40'h3E_41_41_51_32;
                7'd40: c = 40'h7F_08_08_08_7F;
                7'd41: c = 40'h00_41_7F_41_00;
                7'd42: c = 40'h20_40_41_3F_01;
                7'd43: c = 40'h7F_08_14_22_41;
                7'd44: c = 40'h7F_40_40_40_40;
                7'd45: c = 40'h7F_02_04_02_7F;
                7'd46: c = 40'h7F_04_08_10_7F;
                7'd47: c = 40'h3E_41_41_41_3E;
                7'd48: c = 40'h7F_09_09_09_06;
                7'd49: c = 40'h3E_41_51_21_5E;
                7'd50: c = 40'h7F_09_19_29_46;
                7'd51: c = 40'h46_49_49_49_31;
                7'd52: c = 40'h01_01_7F_01_01;
                7'd53: c = 40'h3F_40_40_40_3F;
                7'd54: c = 40'h1F_20_40_20_1F;
                7'd55: c = 40'h7F_20_18_20_7F;
                7'd56: c = 40'h63_14_08_14_63;
                7'd57: c = 40'h03_04_78_04_03;
                7'd58: c = 40'h61_51_49_45_43;
                7'd59: c = 40'h00_00_7F_41_41;
                7'd60: c = 40'h02_04_08_10_20;
                7'd61: c = 40'h41_41_7F_00_00;
                7'd62: c = 40'h04_02_01_02_04;
                7'd63: c = 40'h40_40_40_40_40;
                7'd64: c = 40'h00_01_02_04_00;
                7'd65: c = 40'h20_54_54_54_78;
                7'd66: c = 40'h7F_48_44_44_38;
                7'd67: c = 40'h38_44_44_44_20;
                7'd68: c = 40'h38_44_44_48_7F;
                7'd69: c = 40'h38_54_54_54_18;
                7'd70: c = 40'h08_7E_09_01_02;
                7'd71: c = 40'h08_14_54_54_3C;
                7'd72: c = 40'h7F_08_04_04_78;
                7'd73: c = 40'h00_44_7D_40_00;
                7'd74: c = 40'h20_40_44_3D_00;
                7'd75: c = 40'h00_7F_10_28_44;
                7'd76: c = 40'h00_41_7F_40_00;
                7'd77: c = 40'h7C_04_18_04_78;
                7'd78: c = 40'h7C_08_04_04_78;
                7'd79: c = 40'h38_44_44_44_38;
                7'd80: c = 40'h7C_14_14_14_08;
                7'd81: c = 40'h08_14_14_18_7C;
                7'd82: c = 40'h7C_08_04_04_08;
                7'd83: c = 40'h48_54_54_54_20;
                7'd84: c = 40'h04_3F_44_40_20;
                7'd85: c = 40'h3C_40_40_20_7C;
                7'd86: c = 40'h1C_20_40_20_1C;
                7'd87: c = 40'h3C_40_30_40_3C;
                7'd88: c = 40'h44_28_10_28_44;
                7'd89: c = 40'h0C_50_50_50_3C;
                7'd90: c = 40'h44_64_54_4C_44;
                7'd91: c = 40'h00_08_36_41_00;
                7'd92: c = 40'h00_00_7F_00_00;
                7'd93: c = 40'h00_41_36_08_00;
                7'd94: c = 40'h08_08_2A_1C_08;
                7'd95: c = 40'h08_1C_2A_08_08;
                default: c = 40'h00_00_00_00_00;
            endcase
            return c;
        end
    endfunction

    function automatic logic [ColW-1:0] bit_col(input logic [BitIdxW-1:0] k);
        logic [ColW-1:0] c;
        begin
            if (k >= BitIdxW'(4 * GlyphRows))
                c = ColW'(4);
            else if (k >= BitIdxW'(3 * GlyphRows))
                c = ColW'(3);
            else if (k >= BitIdxW'(2 * GlyphRows))
                c = ColW'(2);
            else if (k >= BitIdxW'(GlyphRows))
                c = ColW'(1);
            else
                c = ColW'(0);
            return c;
        end
    endfunction

    function automatic logic [RowW-1:0] bit_row(input logic [BitIdxW-1:0] k,
                                                input logic [ColW-1:0] c);
        logic [BitIdxW-1:0] r;
        begin
            r = k - BitIdxW'(c * GlyphRows);
            return r[RowW-1:0];
        end
    endfunction

endpackage

@@ hw/rtl/gcr_front.sv @@
module gcr_front (
    input  gcr_pkg::in_item_t in_item,
    input  logic              push,
    input  logic              q_full,
    output logic              q_wr,
    output gcr_pkg::job_t     q_wdata
);

    logic [7:0]  code;
    logic [7:0]  idx_wide;
    logic [39:0] cols;

    always_comb
    begin
        if (in_item.char_code < gcr_pkg::CodeFirst || in_item.char_code > gcr_pkg::CodeLast)
            code = gcr_pkg::CodeFirst;
        else
            code = in_item.char_code;
        idx_wide = code - gcr_pkg::CodeFirst;
        cols     = gcr_pkg::glyph_cols(idx_wide[6:0]);
        for (int c = 0; c < gcr_pkg::GlyphCols; c++)
        begin
            q_wdata.pixels[c*gcr_pkg::GlyphRows +: gcr_pkg::GlyphRows] =
                cols[32-8*c +: gcr_pkg::GlyphRows];
        end
        q_wdata.pos_x = in_item.pos_x;
        q_wdata.pos_y = in_item.pos_y;
    end

    // blank glyphs produce nothing and are dropped here
    assign q_wr = push && !q_full && (|q_wdata.pixels);

endmodule

@@ hw/rtl/gcr_job_queue.sv @@
module gcr_job_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  gcr_pkg::job_t wdata,
    input  logic          rd,
    output gcr_pkg::job_t rdata,
    output logic          full,
    output logic          not_empty
);

    gcr_pkg::job_t mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign rdata     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr;
        rd_ptr_next = rd_ptr_reg ^ rd;
        count_next  = count_reg + {1'b0, wr} - {1'b0, rd};
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hw/rtl/gcr_back.sv @@
module gcr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [23:0]        font_color,
    input  gcr_pkg::job_t      job,
    input  logic               job_valid,
    output logic               job_take,
    input  logic               pop,
    output logic               empty,
    output gcr_pkg::out_item_t out_item
);

    localparam int unsigned NB = gcr_pkg::GlyphBits;

    logic [NB-1:0]  pixels_reg;
    logic [NB-1:0]  pixels_next;
    logic [9:0]     pos_x_reg;
    logic [9:0]     pos_y_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    gcr_pkg::out_item_t out_reg;

    logic [NB-1:0]  lowest;
    logic [NB-1:0]  rest;
    logic [gcr_pkg::BitIdxW-1:0] k;
    logic [gcr_pkg::ColW-1:0]    col;
    logic [gcr_pkg::RowW-1:0]    row;
    logic           busy;
    logic           adv;
    logic           emit;
    logic           is_last;
    gcr_pkg::out_item_t sq;

    always_comb
    begin
        lowest = pixels_reg & (~pixels_reg + NB'(1));
        rest   = pixels_reg & ~lowest;
        k      = '0;
        for (int i = 0; i < NB; i++)
        begin
            if (lowest[i])
                k = gcr_pkg::BitIdxW'(i);
        end
        col = gcr_pkg::bit_col(k);
        row = gcr_pkg::bit_row(k, col);

        busy    = |pixels_reg;
        adv     = !out_valid_reg || pop;
        emit    = busy && adv;
        is_last = emit && (rest == '0);
        job_take = job_valid && (!busy || is_last);

        if (job_take)
            pixels_next = job.pixels;
        else if (emit)
            pixels_next = rest;
        else
            pixels_next = pixels_reg;

        if (emit)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        sq.square_x    = {1'b0, pos_x_reg} + gcr_pkg::CellOffsetX
                         + {{(10 - gcr_pkg::ColW){1'b0}}, col, 1'b0};
        sq.square_y    = {1'b0, pos_y_reg}
                         + {{(10 - gcr_pkg::RowW){1'b0}}, row, 1'b0};
        sq.fill_argb   = {gcr_pkg::AlphaOpaque, font_color};
        sq.last_square = (rest == '0);
    end

    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            pos_x_reg <= job.pos_x;
            pos_y_reg <= job.pos_y;
        end
        if (emit)
        begin
            out_reg <= sq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixels_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pixels_reg    <= pixels_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hw/rtl/glyph_5x7_cell_renderer.sv @@
// An accepted character goes through the job queue into the bit scanner; each square
// is registered at the output. Throughput: one 2x2 square per cycle from the shared bit
// scanner while it holds a job and the output is free or popped. A character gives one
// square per lit pixel (3 to 20 in this font); a blank glyph takes one input transaction
// and gives no squares. A two-entry job queue decouples input and output.
// Reset: queue and scanner emptied, no result pending, font colour cleared to 0.
module glyph_5x7_cell_renderer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  gcr_pkg::in_item_t  in_item,
    output logic               empty,
    input  logic               pop,
    output gcr_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [23:0]        cfg_data
);

    logic [23:0]   font_color_reg;
    logic [23:0]   font_color_next;
    logic          q_wr;
    logic          q_full;
    logic          q_not_empty;
    logic          q_rd;
    gcr_pkg::job_t q_wdata;
    gcr_pkg::job_t q_rdata;

    assign cfg_ready       = 1'b1;
    assign full            = q_full;
    assign font_color_next = (cfg_valid && cfg_ready) ? cfg_data : font_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_color_reg <= '0;
        end
        else
        begin
            font_color_reg <= font_color_next;
        end
    end

    gcr_front u_front (
        .in_item (in_item),
        .push    (push),
        .q_full  (q_full),
        .q_wr    (q_wr),
        .q_wdata (q_wdata)
    );

    gcr_job_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (q_wr),
        .wdata     (q_wdata),
        .rd        (q_rd),
        .rdata     (q_rdata),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    gcr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .font_color (font_color_reg),
        .job        (q_rdata),
        .job_valid  (q_not_empty),
        .job_take   (q_rd),
        .pop        (pop),
        .empty      (empty),
        .out_item   (out_item)
    );

endmodule

@@ sim/glyph_5x7_cell_renderer_test.sv @@
module glyph_5x7_cell_renderer_test;

    timeunit 1ns;
    timeprecision 1ps;

    // 5x7 font, column 0 in the top byte, bit 0 of each column is the top row
    localparam logic [39:0] GlyphTable [96] = '{
        40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
        40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
        40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h08_2A_1C_2A_08, 40'h08_08_3E_08_08,
        40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
        40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
        40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
        40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
        40'h00_08_14_22_41, 40'h14_14_14_14_14, 40'h41_22_14_08_00, 40'h02_01_51_09_06,
        40'h32_49_79_41_3E, 40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
        40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_01_01, 40'h3E_41_41_51_32,
        40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
        40'h7F_40_40_40_40, 40'h7F_02_04_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
        40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31,
        40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h7F_20_18_20_7F,
        40'h63_14_08_14_63, 40'h03_04_78_04_03, 40'h61_51_49_45_43, 40'h00_00_7F_41_41,
        40'h02_04_08_10_20, 40'h41_41_7F_00_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40,
        40'h00_01_02_04_00, 40'h20_54_54_54_78, 40'h7F_48_44_44_38, 40'h38_44_44_44_20,
        40'h38_44_44_48_7F, 40'h38_54_54_54_18, 40'h08_7E_09_01_02, 40'h08_14_54_54_3C,
        40'h7F_08_04_04_78, 40'h00_44_7D_40_00, 40'h20_40_44_3D_00, 40'h00_7F_10_28_44,
        40'h00_41_7F_40_00, 40'h7C_04_18_04_78, 40'h7C_08_04_04_78, 40'h38_44_44_44_38,
        40'h7C_14_14_14_08, 40'h08_14_14_18_7C, 40'h7C_08_04_04_08, 40'h48_54_54_54_20,
        40'h04_3F_44_40_20, 40'h3C_40_40_20_7C, 40'h1C_20_40_20_1C, 40'h3C_40_30_40_3C,
        40'h44_28_10_28_44, 40'h0C_50_50_50_3C, 40'h44_64_54_4C_44, 40'h00_08_36_41_00,
        40'h00_00_7F_00_00, 40'h00_41_36_08_00, 40'h08_08_2A_1C_08, 40'h08_1C_2A_08_08
    };

    class glyph_square_predictor;
        logic [23:0]        font_rgb;
        gcr_pkg::out_item_t squares_due[$];
        int                 mismatches;

        function new();
            font_rgb   = 24'h000000;
            mismatches = 0;
        endfunction

        function int pending();
            return squares_due.size();
        endfunction

        function void note_char(input gcr_pkg::in_item_t c);
            logic [7:0]         code;
            logic [39:0]        cols;
            logic [7:0]         colbits;
            gcr_pkg::out_item_t sq;
            int                 first;
            code  = c.char_code;
            first = squares_due.size();
            if (code < gcr_pkg::CodeFirst || code > gcr_pkg::CodeLast)
                code = gcr_pkg::CodeFirst;
            cols = GlyphTable[code - gcr_pkg::CodeFirst];
            for (int col = 0; col < 5; col++)
            begin
                colbits = cols[39 - 8 * col -: 8];
                for (int row = 0; row < 7; row++)
                begin
                    if (colbits[row])
                    begin
                        sq.square_x    = {1'b0, c.pos_x} + 11'd2 + 11'(2 * col);
                        sq.square_y    = {1'b0, c.pos_y} + 11'(2 * row);
                        sq.fill_argb   = {gcr_pkg::AlphaOpaque, font_rgb};
                        sq.last_square = 1'b0;
                        squares_due.push_back(sq);
                    end
                end
            end
            if (squares_due.size() > first)
                squares_due[squares_due.size() - 1].last_square = 1'b1;
        endfunction

        function void check_square(input gcr_pkg::out_item_t got);
            gcr_pkg::out_item_t want;
            if (squares_due.size() == 0)
            begin
                $display("%0t: unexpected square x=%0d y=%0d argb=%h last=%b", $time,
                         got.square_x, got.square_y, got.fill_argb, got.last_square);
                mismatches++;
                return;
            end
            want = squares_due.pop_front();
            if (got.square_x !== want.square_x)
            begin
                $display("%0t: square_x expected %0d, got %0d", $time,
                         want.square_x, got.square_x);
                mismatches++;
            end
            if (got.square_y !== want.square_y)
            begin
                $display("%0t: square_y expected %0d, got %0d", $time,
                         want.square_y, got.square_y);
                mismatches++;
            end
            if (got.fill_argb !== want.fill_argb)
            begin
                $display("%0t: fill_argb expected %h, got %h", $time,
                         want.fill_argb, got.fill_argb);
                mismatches++;
            end
            if (got.last_square !== want.last_square)
            begin
                $display("%0t: last_square expected %b, got %b", $time,
                         want.last_square, got.last_square);
                mismatches++;
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               push      = 1'b0;
    logic               full;
    gcr_pkg::in_item_t  char_in   = '0;
    logic               empty;
    logic               pop       = 1'b0;
    gcr_pkg::out_item_t square_out;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [23:0]        cfg_data  = 24'h000000;

    bit idle_on  = 1'b0;
    bit hold_req = 1'b0;

    glyph_square_predictor sb;

    glyph_5x7_cell_renderer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (char_in),
        .empty     (empty),
        .pop       (pop),
        .out_item  (square_out),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic gcr_pkg::in_item_t glyph_at(input logic [7:0] code,
                                                   input logic [9:0] x,
                                                   input logic [9:0] y);
        gcr_pkg::in_item_t it;
        it.char_code = code;
        it.pos_x     = x;
        it.pos_y     = y;
        return it;
    endfunction

    function automatic logic [9:0] rand_pos();
        case ($urandom_range(0, 7))
            0: return 10'd0;
            1: return 10'd1023;
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic gcr_pkg::in_item_t rand_char();
        logic [7:0] code;
        if ($urandom_range(0, 3) == 0)
            code = 8'($urandom_range(0, 255));
        else
            code = 8'($urandom_range(32, 125));
        return glyph_at(code, rand_pos(), rand_pos());
    endfunction

    // leaves push high; the caller lowers it when the run of characters ends
    task automatic send_char(input gcr_pkg::in_item_t it);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        push    <= 1'b1;
        char_in <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_char(it);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_char(rand_char());
        push <= 1'b0;
    endtask

    // blank glyphs give no squares, so wait past the last square for them to leave
    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_font_colour(input logic [23:0] rgb);
        cfg_valid <= 1'b1;
        cfg_data  <= rgb;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.font_rgb = rgb;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : square_sink
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                sb.check_square(square_out);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall    = 300;
            end
            if (stall > 0)
            begin
                stall--;
                pop <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 16) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin : stimulus
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_font_colour(24'hFFFFFF);
        idle_on = 1'b1;
        send_char(glyph_at(8'd0,   10'd0,    10'd0));
        send_char(glyph_at(8'd31,  10'd1023, 10'd0));
        send_char(glyph_at(8'd32,  10'd0,    10'd1023));
        send_char(glyph_at(8'd33,  10'd0,    10'd0));
        send_char(glyph_at(8'd35,  10'd1023, 10'd1023));
        send_char(glyph_at(8'd48,  10'h2AA,  10'h155));
        send_char(glyph_at(8'd64,  10'h155,  10'h2AA));
        send_char(glyph_at(8'd65,  10'd1023, 10'd1023));
        send_char(glyph_at(8'd66,  10'd0,    10'd1023));
        send_char(glyph_at(8'd95,  10'd512,  10'd511));
        send_char(glyph_at(8'd124, 10'd1,    10'd1022));
        send_char(glyph_at(8'd125, 10'd1023, 10'd1023));
        send_char(glyph_at(8'd126, 10'd100,  10'd200));
        send_char(glyph_at(8'd127, 10'd300,  10'd400));
        send_char(glyph_at(8'd128, 10'd1022, 10'd1));
        send_char(glyph_at(8'd255, 10'd1023, 10'd1023));
        send_char(glyph_at(8'd87,  10'd1023, 10'd0));
        send_char(glyph_at(8'd77,  10'd0,    10'd1023));
        push <= 1'b0;
        wait_drained();

        set_font_colour(24'h000000);
        send_random(79);
        wait_drained();

        set_font_colour(24'($urandom_range(0, 24'hFFFFFF)));
        hold_req = 1'b1;
        send_random(79);
        wait_drained();

        set_font_colour(24'($urandom_range(0, 24'hFFFFFF)));
        idle_on = 1'b0;
        send_random(79);
        wait_drained();

        set_font_colour(24'hA5A55A);
        idle_on = 1'b1;
        send_random(79);
        wait_drained();

        set_font_colour(24'($urandom_range(0, 24'hFFFFFF)));
        idle_on = 1'b0;
        send_random(79);
        wait_drained();

        if (sb.mismatches == 0)
            $display("[glyph_5x7_cell_renderer] OK");
        else
            $display("[glyph_5x7_cell_renderer] ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("[glyph_5x7_cell_renderer] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/gcr_pkg.sv
hw/rtl/gcr_front.sv
hw/rtl/gcr_job_queue.sv
hw/rtl/gcr_back.sv
hw/rtl/glyph_5x7_cell_renderer.sv
sim/glyph_5x7_cell_renderer_test.sv
